FILE: src/lbc_pkg.sv
package lbc_pkg;

   // Default width of the phase length fields
   localparam int TIME_WIDTH_DEF = 16;

   // Fixed item field widths
   localparam int OP_WIDTH    = 3;
   localparam int COUNT_WIDTH = 8;

   // Configuration port
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int MODE_WIDTH     = 2;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_ADDR_LED_MODE = 3'd0;

   // LED mode register codes
   localparam logic [MODE_WIDTH-1:0] MODE_OFF   = 2'd0;
   localparam logic [MODE_WIDTH-1:0] MODE_ON    = 2'd1;
   localparam logic [MODE_WIDTH-1:0] MODE_RELAY = 2'd2;
   localparam logic [MODE_WIDTH-1:0] MODE_RESET = MODE_RELAY;

   // Request operations
   typedef enum logic [OP_WIDTH-1:0] {
      OP_TICK        = 3'd0,
      OP_BLINK_START = 3'd1,
      OP_BLINK_STOP  = 3'd2,
      OP_LIGHT_ON    = 3'd3,
      OP_LIGHT_OFF   = 3'd4
   } op_type;

   // Handshake between the input stage and the core
   typedef struct packed {
      logic valid;
      logic pop;
   } stage_ctl_type;

endpackage

FILE: src/lbc_csr.sv
module lbc_csr (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [lbc_pkg::CSR_ADDR_WIDTH-1:0]     csr_paddr,
   input  logic [lbc_pkg::CSR_DATA_WIDTH-1:0]     csr_pwdata,
   output logic [lbc_pkg::CSR_DATA_WIDTH-1:0]     csr_prdata,
   output logic                                   csr_pready,
   output logic [lbc_pkg::MODE_WIDTH-1:0]         led_mode
);

   logic [lbc_pkg::MODE_WIDTH-1:0] mode_ff;
   logic [lbc_pkg::MODE_WIDTH-1:0] mode_in;
   logic                           wr_en;
   logic                           sel_mode;

   assign csr_pready = 1'b1;
   assign sel_mode   = (csr_paddr == lbc_pkg::CSR_ADDR_LED_MODE);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   // Mode register write
   always_comb begin
      mode_in = mode_ff;
      if (wr_en && sel_mode) begin
         mode_in = csr_pwdata[lbc_pkg::MODE_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= lbc_pkg::MODE_RESET;
      end else begin
         mode_ff <= mode_in;
      end
   end

   // Read back; unmapped addresses read zero
   always_comb begin
      csr_prdata = '0;
      if (sel_mode) begin
         csr_prdata = {{(lbc_pkg::CSR_DATA_WIDTH-lbc_pkg::MODE_WIDTH){1'b0}}, mode_ff};
      end
   end

   assign led_mode = mode_ff;

endmodule

FILE: src/lbc_in_stage.sv
module lbc_in_stage #(
   parameter int DATA_WIDTH = 48
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [lbc_pkg::OP_WIDTH-1:0]   req_tuser,
   input  logic [DATA_WIDTH-1:0]          req_tdata,
   input  logic                           pop,
   output lbc_pkg::stage_ctl_type         ctl,
   output logic [lbc_pkg::OP_WIDTH-1:0]   op,
   output logic [DATA_WIDTH-1:0]          data
);

   logic                         valid_ff;
   logic                         valid_in;
   logic [lbc_pkg::OP_WIDTH-1:0] op_ff;
   logic [DATA_WIDTH-1:0]        data_ff;
   logic                         take;

   // Room when empty or when the held beat leaves this cycle
   assign req_tready = ~valid_ff | pop;
   assign take       = req_tvalid & req_tready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset
   always_ff @(posedge clock) begin
      if (take) begin
         op_ff   <= req_tuser;
         data_ff <= req_tdata;
      end
   end

   assign ctl.valid = valid_ff;
   assign ctl.pop   = pop;
   assign op        = op_ff;
   assign data      = data_ff;

endmodule

FILE: src/lbc_core.sv
module lbc_core #(
   parameter int TIME_WIDTH = lbc_pkg::TIME_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  lbc_pkg::stage_ctl_type            in_ctl,
   output logic                              pop,
   input  logic [lbc_pkg::OP_WIDTH-1:0]      op,
   input  logic [lbc_pkg::COUNT_WIDTH-1:0]   blink_count,
   input  logic [TIME_WIDTH-1:0]             on_ticks,
   input  logic [TIME_WIDTH-1:0]             off_ticks,
   input  logic                              onoff_attr,
   input  logic                              relay_on,
   input  logic [lbc_pkg::MODE_WIDTH-1:0]    led_mode,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic                              led_level,
   output logic                              blink_active
);

   localparam logic [TIME_WIDTH-1:0] TICK_ONE = TIME_WIDTH'(1);
   localparam logic [lbc_pkg::COUNT_WIDTH-1:0] COUNT_ONE = lbc_pkg::COUNT_WIDTH'(1);

   logic                            blinking_ff, blinking_in;
   logic                            phase_ff, phase_in;
   logic                            orig_ff, orig_in;
   logic [lbc_pkg::COUNT_WIDTH-1:0] left_ff, left_in;
   logic [TIME_WIDTH-1:0]           on_ff, on_in;
   logic [TIME_WIDTH-1:0]           off_ff, off_in;
   logic [TIME_WIDTH-1:0]           cd_ff, cd_in;
   logic                            led_ff, led_in;
   logic                            out_valid_ff, out_valid_in;
   logic                            step;
   logic                            mode_led;
   logic                            mode_sets;
   logic [TIME_WIDTH-1:0]           start_len;
   logic [TIME_WIDTH-1:0]           next_len;

   // Item moves on when the result register is free or being drained
   assign step = in_ctl.valid & (~out_valid_ff | rsp_tready);
   assign pop  = step;

   // LED level dictated by the mode; mode 3 leaves the LED alone
   always_comb begin
      mode_sets = 1'b1;
      mode_led  = led_ff;
      case (led_mode)
         lbc_pkg::MODE_OFF:   mode_led = 1'b0;
         lbc_pkg::MODE_ON:    mode_led = 1'b1;
         lbc_pkg::MODE_RELAY: mode_led = relay_on;
         default:             mode_sets = 1'b0;
      endcase
   end

   // Phase lengths, zero counts as one tick
   always_comb begin
      start_len = onoff_attr ? off_ticks : on_ticks;
      if (start_len == '0) begin
         start_len = TICK_ONE;
      end
      next_len = phase_ff ? off_ff : on_ff;
      if (next_len == '0) begin
         next_len = TICK_ONE;
      end
   end

   // State update for one item
   always_comb begin
      blinking_in = blinking_ff;
      phase_in    = phase_ff;
      orig_in     = orig_ff;
      left_in     = left_ff;
      on_in       = on_ff;
      off_in      = off_ff;
      cd_in       = cd_ff;
      led_in      = led_ff;
      if (step) begin
         unique case (lbc_pkg::op_type'(op))
            lbc_pkg::OP_TICK: begin
               if (blinking_ff) begin
                  if (cd_ff > TICK_ONE) begin
                     cd_in = cd_ff - TICK_ONE;
                  end else if (phase_ff == orig_ff && left_ff <= COUNT_ONE) begin
                     // last blink used up
                     left_in     = '0;
                     blinking_in = 1'b0;
                     cd_in       = '0;
                     if (mode_sets) begin
                        led_in = mode_led;
                     end
                  end else begin
                     if (phase_ff == orig_ff) begin
                        left_in = left_ff - COUNT_ONE;
                     end
                     phase_in = ~phase_ff;
                     led_in   = ~phase_ff;
                     cd_in    = next_len;
                  end
               end
            end
            lbc_pkg::OP_BLINK_START: begin
               left_in = blink_count;
               if (!blinking_ff) begin
                  orig_in     = onoff_attr;
                  phase_in    = ~onoff_attr;
                  led_in      = ~onoff_attr;
                  on_in       = on_ticks;
                  off_in      = off_ticks;
                  cd_in       = start_len;
                  blinking_in = 1'b1;
               end
            end
            lbc_pkg::OP_BLINK_STOP: begin
               if (blinking_ff) begin
                  blinking_in = 1'b0;
                  left_in     = '0;
                  cd_in       = '0;
               end
               if (mode_sets) begin
                  led_in = mode_led;
               end
            end
            lbc_pkg::OP_LIGHT_ON: begin
               if (!blinking_ff && led_mode != lbc_pkg::MODE_OFF) begin
                  led_in = 1'b1;
               end
            end
            lbc_pkg::OP_LIGHT_OFF: begin
               if (!blinking_ff && led_mode != lbc_pkg::MODE_ON) begin
                  led_in = 1'b0;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blinking_ff <= 1'b0;
         phase_ff    <= 1'b0;
         orig_ff     <= 1'b0;
         left_ff     <= '0;
         on_ff       <= '0;
         off_ff      <= '0;
         cd_ff       <= '0;
         led_ff      <= 1'b0;
      end else begin
         blinking_ff <= blinking_in;
         phase_ff    <= phase_in;
         orig_ff     <= orig_in;
         left_ff     <= left_in;
         on_ff       <= on_in;
         off_ff      <= off_in;
         cd_ff       <= cd_in;
         led_ff      <= led_in;
      end
   end

   // Result register: the state registers double as the result payload
   always_comb begin
      out_valid_in = out_valid_ff;
      if (step) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_tvalid   = out_valid_ff;
   assign led_level    = led_ff;
   assign blink_active = blinking_ff;

endmodule

FILE: src/led_blink_controller.sv
// LED blink controller.
// Path: request beat -> input register -> state/result register -> result beat.
// One request per cycle unless a result beat is stalled; the state update is combinational.
// Reset (synchronous, active high) stops blinking, turns the LED off, empties both
// registers and sets the LED mode to follow the relay.
module led_blink_controller #(
   parameter int TIME_WIDTH = lbc_pkg::TIME_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // tuser: operation[2:0]
   input  logic [lbc_pkg::OP_WIDTH-1:0]        req_tuser,
   // tdata: blink_count[7:0], on_ticks, off_ticks, onoff_attr, relay_on, zero pad
   input  logic [((lbc_pkg::COUNT_WIDTH+2*TIME_WIDTH+2+7)/8)*8-1:0] req_tdata,
   // result
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // tdata: led_level[0], blink_active[1], zero pad
   output logic [7:0]                          rsp_tdata,
   // configuration
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [lbc_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [lbc_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [lbc_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                csr_pready
);

   localparam int REQ_BITS  = lbc_pkg::COUNT_WIDTH + 2*TIME_WIDTH + 2;
   localparam int REQ_WIDTH = ((REQ_BITS + 7) / 8) * 8;
   localparam int ON_LO     = lbc_pkg::COUNT_WIDTH;
   localparam int OFF_LO    = ON_LO + TIME_WIDTH;
   localparam int ATTR_BIT  = OFF_LO + TIME_WIDTH;
   localparam int RELAY_BIT = ATTR_BIT + 1;

   lbc_pkg::stage_ctl_type           in_ctl;
   logic                             pop;
   logic [lbc_pkg::OP_WIDTH-1:0]     op;
   logic [REQ_WIDTH-1:0]             data;
   logic [lbc_pkg::MODE_WIDTH-1:0]   led_mode;
   logic                             led_level;
   logic                             blink_active;

   lbc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .led_mode    (led_mode)
   );

   lbc_in_stage #(
      .DATA_WIDTH (REQ_WIDTH)
   ) u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .pop        (pop),
      .ctl        (in_ctl),
      .op         (op),
      .data       (data)
   );

   lbc_core #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .in_ctl       (in_ctl),
      .pop          (pop),
      .op           (op),
      .blink_count  (data[lbc_pkg::COUNT_WIDTH-1:0]),
      .on_ticks     (data[ON_LO +: TIME_WIDTH]),
      .off_ticks    (data[OFF_LO +: TIME_WIDTH]),
      .onoff_attr   (data[ATTR_BIT]),
      .relay_on     (data[RELAY_BIT]),
      .led_mode     (led_mode),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .led_level    (led_level),
      .blink_active (blink_active)
   );

   assign rsp_tdata = {6'b0, blink_active, led_level};

endmodule
